FILE: src/tbrms_pkg.sv
// shared constants, codes and arithmetic helpers of the three-band rms analyzer
package tbrms_pkg;

  localparam int unsigned NumBands    = 3;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned MaxBlock    = 4096;
  localparam int unsigned FrameW      = 13;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned LevelW      = 15;
  localparam int unsigned EnergyW     = 48;
  localparam int unsigned HistW       = 32;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned CfgDataW    = 13;

  localparam logic [ChanW-1:0]  ChanReset  = 3'd2;
  localparam logic [FrameW-1:0] BlockReset = 13'd512;
  localparam logic [LevelW-1:0] LevelMax   = 15'h7fff;

  // reciprocal of three for an 18-bit dividend, shift of twenty
  localparam logic [18:0] Recip3 = 19'd349526;

  typedef enum logic [0:0] {
    CFG_CHANNELS = 1'b0,
    CFG_BLOCK    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [HistW-1:0] h0;
    logic signed [HistW-1:0] h1;
  } hist_t;

  function automatic logic signed [31:0] band_gain(input logic [1:0] b);
    logic signed [31:0] r;
    case (b)
      2'd0:    r = 32'sd457384;
      2'd1:    r = 32'sd286207146;
      2'd2:    r = 32'sd665370542;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] band_c0(input logic [1:0] b);
    logic signed [31:0] r;
    case (b)
      2'd0:    r = -32'sd1011982365;
      2'd1:    r = -32'sd547098786;
      2'd2:    r = -32'sd418376768;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] band_c1(input logic [1:0] b);
    logic signed [31:0] r;
    case (b)
      2'd0:    r = 32'sd2083894655;
      2'd1:    r = 32'sd1597365335;
      2'd2:    r = 32'sd1169363578;
      default: r = '0;
    endcase
    return r;
  endfunction

  // add half then floor by 2^30
  function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/three_band_rms_analyzer_unit.sv
// three-band rms analyzer top level: channel mean, three biquads, energy sums, rms levels
//
// Each frame averages the first channels_in_use samples and runs it through low-pass,
// band-pass and high-pass biquads on one shared 32x32 multiplier with a registered product,
// six steps per band, and in_stall_o stays high until the next frame can be taken. The frame
// that closes a block also runs, per band, a 48-step restoring divider by the frame count
// and a 24-step square root, then waits for any previous result to leave the output
// register. A result waits in that register, so the next frame can be taken while it is held.
// Register writes take effect at once, belong between frames and never clear filter state.
module three_band_rms_analyzer_unit
  import tbrms_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_0_i,
  input  logic signed [SampleW-1:0] sample_1_i,
  input  logic signed [SampleW-1:0] sample_2_i,
  input  logic signed [SampleW-1:0] sample_3_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [LevelW-1:0]         bass_level_o,
  output logic [LevelW-1:0]         mid_level_o,
  output logic [LevelW-1:0]         treble_level_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_G, S_MUL_C0, S_MUL_C1, S_SUM, S_SQR, S_ENERGY,
    S_FRAME, S_DIV, S_SQRT, S_LEVEL, S_OUT
  } state_e;

  state_e                    state_q;
  logic [ChanW-1:0]          chan_q;
  logic [FrameW-1:0]         block_q;
  logic [FrameW-1:0]         fc_q;
  logic [1:0]                band_q;
  hist_t                     xh_q [NumBands];
  hist_t                     yh_q [NumBands];
  logic [EnergyW-1:0]        energy_q [NumBands];
  logic [LevelW-1:0]         level_q [NumBands];
  logic signed [31:0]        mean_q;
  logic signed [63:0]        p_q;
  logic signed [31:0]        x2_q;
  logic signed [36:0]        acc_q;
  logic signed [31:0]        y2_q;
  logic [FrameW:0]           frames_q;
  logic [EnergyW-1:0]        dq_q;
  logic [FrameW:0]           rem_q;
  logic [5:0]                it_q;
  logic [EnergyW-1:0]        v_q;
  logic [EnergyW-1:0]        res_q;
  logic [4:0]                k_q;
  logic                      out_valid_q;
  logic [LevelW-1:0]         bass_q, mid_q, treble_q;

  // channel mean
  logic [ChanW-1:0]          n_eff;
  logic signed [17:0]        ssum;
  logic [17:0]               mag;
  logic [36:0]               q3p;
  logic [17:0]               q3;
  logic [17:0]               r3;
  logic [32:0]               mmag;
  logic signed [31:0]        mean_d;

  always_comb begin
    if (chan_q == '0) begin
      n_eff = ChanW'(1);
    end else if (chan_q > ChanW'(MaxChannels)) begin
      n_eff = ChanW'(MaxChannels);
    end else begin
      n_eff = chan_q;
    end
    if (n_eff > 3'd4) n_eff = 3'd4;
    ssum = 18'(sample_0_i);
    if (n_eff >= 3'd2) ssum = ssum + 18'(sample_1_i);
    if (n_eff >= 3'd3) ssum = ssum + 18'(sample_2_i);
    if (n_eff >= 3'd4) ssum = ssum + 18'(sample_3_i);
    mag = ssum[17] ? 18'(-ssum) : 18'(ssum);
    q3p = 37'(mag) * 37'(Recip3);
    q3  = 18'(q3p[36:20]);
    r3  = mag - 18'(q3 * 18'd3);
    case (n_eff)
      3'd2: mmag = 33'(mag) << 14;
      3'd3: begin
        mmag = 33'(q3) << 15;
        case (r3[1:0])
          2'd1:    mmag = mmag + 33'd10922;
          2'd2:    mmag = mmag + 33'd21845;
          default: mmag = mmag;
        endcase
      end
      3'd4: mmag = 33'(mag) << 13;
      default: mmag = 33'(mag) << 15;
    endcase
    mean_d = ssum[17] ? 32'(-mmag) : 32'(mmag);
  end

  // shared multiplier operands
  logic signed [31:0] mul_a, mul_b;
  logic signed [17:0] qv;
  logic signed [32:0] qr;

  always_comb begin
    qr = 33'(y2_q) + 33'sd16384;
    qv = qr[32:15];
    case (state_q)
      S_MUL_G:  begin mul_a = mean_q;           mul_b = band_gain(band_q); end
      S_MUL_C0: begin mul_a = yh_q[band_q].h0;  mul_b = band_c0(band_q);   end
      S_MUL_C1: begin mul_a = yh_q[band_q].h1;  mul_b = band_c1(band_q);   end
      S_SQR:    begin mul_a = 32'(qv);          mul_b = 32'(qv);           end
      default:  begin mul_a = '0;               mul_b = '0;                end
    endcase
  end

  // feed-forward taps and band output
  logic signed [36:0] taps;
  logic signed [31:0] y_new;
  logic [EnergyW:0]   esum;

  always_comb begin
    case (band_q)
      2'd0:    taps = 37'(xh_q[band_q].h0) + (37'(xh_q[band_q].h1) <<< 1);
      2'd1:    taps = -37'(xh_q[band_q].h0);
      default: taps = 37'(xh_q[band_q].h0) - (37'(xh_q[band_q].h1) <<< 1);
    endcase
    y_new = sat32(acc_q + 37'(round_q30(p_q)));
    esum  = {1'b0, energy_q[band_q]} + (EnergyW+1)'(p_q[32:0]);
  end

  // frame count and block end
  logic [FrameW-1:0] len_eff;
  logic [FrameW-1:0] fc_next;
  logic              blk_end;

  always_comb begin
    if (block_q == '0) begin
      len_eff = FrameW'(1);
    end else if (block_q > FrameW'(MaxBlock)) begin
      len_eff = FrameW'(MaxBlock);
    end else begin
      len_eff = block_q;
    end
    fc_next = fc_q + FrameW'(1);
    blk_end = (fc_next == '0) || (fc_next >= len_eff);
  end

  // divider and square root steps
  logic [FrameW:0]    dt;
  logic               dge;
  logic [EnergyW-1:0] sbit;
  logic [EnergyW-1:0] st;
  logic               sge;
  logic [EnergyW-1:0] res_next;

  always_comb begin
    dt       = {rem_q[FrameW-1:0], dq_q[EnergyW-1]};
    dge      = dt >= frames_q;
    sbit     = EnergyW'(1) << {k_q, 1'b0};
    st       = res_q + sbit;
    sge      = v_q >= st;
    res_next = sge ? (res_q >> 1) + sbit : res_q >> 1;
  end

  logic out_take;
  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chan_q      <= ChanReset;
      block_q     <= BlockReset;
      fc_q        <= '0;
      band_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBands; i++) begin
        xh_q[i]     <= '0;
        yh_q[i]     <= '0;
        energy_q[i] <= '0;
        level_q[i]  <= '0;
      end
      mean_q   <= '0;
      p_q      <= '0;
      x2_q     <= '0;
      acc_q    <= '0;
      y2_q     <= '0;
      frames_q <= '0;
      dq_q     <= '0;
      rem_q    <= '0;
      it_q     <= '0;
      v_q      <= '0;
      res_q    <= '0;
      k_q      <= '0;
      bass_q   <= '0;
      mid_q    <= '0;
      treble_q <= '0;
    end else begin
      p_q <= mul_a * mul_b;
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CHANNELS: chan_q  <= cfg_wdata_i[ChanW-1:0];
          CFG_BLOCK:    block_q <= cfg_wdata_i[FrameW-1:0];
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mean_q  <= mean_d;
            band_q  <= '0;
            state_q <= S_MUL_G;
          end
        end
        S_MUL_G:  state_q <= S_MUL_C0;
        S_MUL_C0: begin
          x2_q    <= 32'(round_q30(p_q));
          state_q <= S_MUL_C1;
        end
        S_MUL_C1: begin
          acc_q   <= taps + 37'(x2_q) + 37'(round_q30(p_q));
          state_q <= S_SUM;
        end
        S_SUM: begin
          xh_q[band_q] <= '{h0: xh_q[band_q].h1, h1: x2_q};
          yh_q[band_q] <= '{h0: yh_q[band_q].h1, h1: y_new};
          y2_q         <= y_new;
          state_q      <= S_SQR;
        end
        S_SQR:    state_q <= S_ENERGY;
        S_ENERGY: begin
          energy_q[band_q] <= esum[EnergyW] ? '1 : esum[EnergyW-1:0];
          if (band_q == 2'd2) begin
            band_q  <= '0;
            state_q <= S_FRAME;
          end else begin
            band_q  <= band_q + 2'd1;
            state_q <= S_MUL_G;
          end
        end
        S_FRAME: begin
          if (blk_end) begin
            fc_q     <= '0;
            frames_q <= (fc_next == '0) ? {1'b1, FrameW'(0)} : {1'b0, fc_next};
            dq_q     <= energy_q[0];
            rem_q    <= '0;
            it_q     <= '0;
            state_q  <= S_DIV;
          end else begin
            fc_q    <= fc_next;
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          rem_q <= dge ? dt - frames_q : dt;
          dq_q  <= {dq_q[EnergyW-2:0], dge};
          it_q  <= it_q + 6'd1;
          if (it_q == 6'(EnergyW - 1)) begin
            v_q     <= {dq_q[EnergyW-2:0], dge};
            res_q   <= '0;
            k_q     <= 5'(EnergyW / 2 - 1);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sge) v_q <= v_q - st;
          res_q <= res_next;
          k_q   <= k_q - 5'd1;
          if (k_q == '0) state_q <= S_LEVEL;
        end
        S_LEVEL: begin
          level_q[band_q]  <= (res_q > EnergyW'(LevelMax)) ? LevelMax : res_q[LevelW-1:0];
          energy_q[band_q] <= '0;
          if (band_q == 2'd2) begin
            band_q  <= '0;
            state_q <= S_OUT;
          end else begin
            band_q  <= band_q + 2'd1;
            dq_q    <= energy_q[band_q + 2'd1];
            rem_q   <= '0;
            it_q    <= '0;
            state_q <= S_DIV;
          end
        end
        S_OUT: begin
          if (out_take) begin
            bass_q      <= level_q[0];
            mid_q       <= level_q[1];
            treble_q    <= level_q[2];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign bass_level_o   = bass_q;
  assign mid_level_o    = mid_q;
  assign treble_level_o = treble_q;

endmodule

FILE: verif/tb_three_band_rms_analyzer_unit.sv
// testbench for the three-band rms analyzer: predicted band levels checked under random flow control
module tb_three_band_rms_analyzer_unit;
  import tbrms_pkg::*;

  typedef struct {
    logic [LevelW-1:0] bass;
    logic [LevelW-1:0] mid;
    logic [LevelW-1:0] treble;
  } levels_t;

  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles  = 320;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [0:0]                cfg_idx_i = CFG_CHANNELS;
  logic [CfgDataW-1:0]       cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_0_i = '0;
  logic signed [SampleW-1:0] sample_1_i = '0;
  logic signed [SampleW-1:0] sample_2_i = '0;
  logic signed [SampleW-1:0] sample_3_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [LevelW-1:0]         bass_level_o;
  logic [LevelW-1:0]         mid_level_o;
  logic [LevelW-1:0]         treble_level_o;

  three_band_rms_analyzer_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .sample_0_i, .sample_1_i, .sample_2_i, .sample_3_i,
    .out_valid_o, .out_stall_i, .bass_level_o, .mid_level_o, .treble_level_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // filter coefficients, q2.30
  const longint GainQ30[3] = '{457384, 286207146, 665370542};
  const longint C0Q30[3]   = '{-1011982365, -547098786, -418376768};
  const longint C1Q30[3]   = '{2083894655, 1597365335, 1169363578};
  const longint Tap0[3]    = '{1, -1, 1};
  const longint Tap1[3]    = '{2, 0, -2};

  logic [ChanW-1:0]  chan_cfg = ChanReset;
  logic [FrameW-1:0] block_cfg = BlockReset;
  longint            x_hist[6];
  longint            y_hist[6];
  longint unsigned   band_energy[3];
  logic [FrameW-1:0] frames_seen = '0;
  levels_t           level_queue[$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic longint round_q30_tb(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_levels(input logic signed [SampleW-1:0] s[4]);
    int              n;
    int              len;
    longint          acc;
    longint          mean;
    longint          x2;
    longint          y2;
    longint          q;
    longint unsigned e;
    longint unsigned frames;
    longint unsigned r[3];
    levels_t         lv;
    n = chan_cfg;
    if (n == 0) n = 1;
    if (n > MaxChannels) n = MaxChannels;
    len = block_cfg;
    if (len == 0) len = 1;
    if (len > MaxBlock) len = MaxBlock;
    acc = 0;
    for (int i = 0; i < n; i++) acc += longint'(s[i]);
    mean = (acc * 32768) / longint'(n);
    for (int b = 0; b < 3; b++) begin
      x2 = round_q30_tb(mean * GainQ30[b]);
      y2 = Tap0[b] * x_hist[2*b] + Tap1[b] * x_hist[2*b+1] + x2
         + round_q30_tb(C0Q30[b] * y_hist[2*b]) + round_q30_tb(C1Q30[b] * y_hist[2*b+1]);
      if (y2 > 64'sd2147483647) y2 = 64'sd2147483647;
      if (y2 < -64'sd2147483648) y2 = -64'sd2147483648;
      x_hist[2*b] = x_hist[2*b+1];
      x_hist[2*b+1] = x2;
      y_hist[2*b] = y_hist[2*b+1];
      y_hist[2*b+1] = y2;
      q = (y2 + 16384) >>> 15;
      e = band_energy[b] + longint'(q * q);
      band_energy[b] = (e > 64'hffff_ffff_ffff) ? 64'hffff_ffff_ffff : e;
    end
    frames_seen = frames_seen + 1'b1;
    if (frames_seen == 0 || frames_seen >= len) begin
      frames = (frames_seen != 0) ? frames_seen : 64'h2000;
      for (int b = 0; b < 3; b++) begin
        r[b] = int_sqrt(band_energy[b] / frames);
        if (r[b] > LevelMax) r[b] = LevelMax;
        band_energy[b] = 0;
      end
      lv.bass = r[0][LevelW-1:0];
      lv.mid = r[1][LevelW-1:0];
      lv.treble = r[2][LevelW-1:0];
      level_queue.push_back(lv);
      frames_seen = '0;
    end
  endtask

  // receiver side: checks results, drives stall, runs the watchdog
  always @(posedge clk_i) begin
    levels_t lv;
    if (out_valid_o && !out_stall_i) begin
      if (level_queue.size() == 0) begin
        $error("unexpected result bass=%0d mid=%0d treble=%0d",
               bass_level_o, mid_level_o, treble_level_o);
        errors++;
      end else begin
        lv = level_queue.pop_front();
        if (bass_level_o !== lv.bass) begin
          $error("bass_level expected %0d actual %0d", lv.bass, bass_level_o);
          errors++;
        end
        if (mid_level_o !== lv.mid) begin
          $error("mid_level expected %0d actual %0d", lv.mid, mid_level_o);
          errors++;
        end
        if (treble_level_o !== lv.treble) begin
          $error("treble_level expected %0d actual %0d", lv.treble, treble_level_o);
          errors++;
        end
      end
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_frame(input logic signed [SampleW-1:0] a, input logic signed [SampleW-1:0] b,
                            input logic signed [SampleW-1:0] c, input logic signed [SampleW-1:0] d);
    logic signed [SampleW-1:0] s[4];
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_0_i <= a;
    sample_1_i <= b;
    sample_2_i <= c;
    sample_3_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    s = '{a, b, c, d};
    predict_levels(s);
  endtask

  task automatic send_random_frame();
    logic signed [SampleW-1:0] s[4];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: s[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        1, 2: s[i] = $signed(16'($urandom_range(2047))) - 16'sd1024;
        default: s[i] = 16'($urandom);
      endcase
    end
    send_frame(s[0], s[1], s[2], s[3]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (level_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ChanW-1:0] ch, input logic [FrameW-1:0] blk);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CHANNELS;
    cfg_wdata_i <= CfgDataW'(ch);
    @(posedge clk_i);
    chan_cfg = ch;
    cfg_idx_i <= CFG_BLOCK;
    cfg_wdata_i <= blk;
    @(posedge clk_i);
    block_cfg = blk;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_extremes();
    set_config(3'd4, 13'd1);
    send_frame(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_frame(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_frame(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_frame(16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff);
    wait_drained();
  endtask

  task automatic test_channel_counts();
    for (int ch = 0; ch < 8; ch++) begin
      set_config(ch[ChanW-1:0], 13'd2);
      send_frame(16'sh7fff, 16'sh8000, 16'sh1234, 16'shedcb);
      send_frame(16'sh8000, 16'sh7fff, 16'sh4000, 16'shc000);
      wait_drained();
    end
  endtask

  task automatic test_block_edges();
    set_config(3'd1, 13'd0);
    send_frame(16'sh4000, 16'sh0, 16'sh0, 16'sh0);
    send_frame(16'shc000, 16'sh0, 16'sh0, 16'sh0);
    wait_drained();
  endtask

  task automatic test_block_shortened();
    set_config(3'd2, 13'd512);
    for (int i = 0; i < 6; i++) send_frame(i[0] ? 16'sh6000 : 16'sha000, 16'sh100, 16'sh0, 16'sh0);
    wait_drained();
    set_config(3'd2, 13'd3);
    send_frame(16'sh2000, 16'sh2000, 16'sh0, 16'sh0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_config(3'd3, 13'd1);
    send_idle = 0;
    hold_cycles = 1500;
    for (int i = 0; i < 12; i++) send_random_frame();
    wait_drained();
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int count, input bit huge);
    int sent;
    int chunk;
    logic [FrameW-1:0] blk;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    if (huge) begin
      set_config(3'($urandom_range(7)), 13'd8191);
      for (int i = 0; i < 300; i++) send_random_frame();
      wait_drained();
    end
    while (sent < count) begin
      case ($urandom_range(9))
        0: blk = 13'd512;
        1: blk = 13'd0;
        default: blk = 13'($urandom_range(16, 1));
      endcase
      set_config(3'($urandom_range(7)), blk);
      chunk = $urandom_range(80, 30);
      for (int i = 0; i < chunk; i++) send_random_frame();
      sent += chunk;
      wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) begin
      x_hist[i] = 0;
      y_hist[i] = 0;
    end
    for (int i = 0; i < 3; i++) band_energy[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_channel_counts();
    test_block_edges();
    test_block_shortened();
    test_backpressure();
    test_random(11, 52, 500, 1'b0);
    test_random(52, 11, 500, 1'b0);
    test_random(0, 0, 500, 1'b1);
    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
